// ===== rtl/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property checked on every clock edge outside reset
`define ALS_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// implication checked on every clock edge outside reset
`define ALS_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// implication whose consequent is checked in the cycle after the antecedent
`define ALS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/als_pkg.sv =====
// types, constants and register map for the accept-language selector
package als_pkg;

    localparam int MAX_HEADER_BYTES = 255;
    localparam int NUM_CODES        = 4;
    localparam int CNT_W            = $clog2(MAX_HEADER_BYTES + 1);

    localparam int NUM_REGS = 5;
    localparam int REG_IDX_W = $clog2(NUM_REGS);

    localparam logic [REG_IDX_W-1:0] REG_CODE_ZERO    = REG_IDX_W'(0);
    localparam logic [REG_IDX_W-1:0] REG_CODE_ONE     = REG_IDX_W'(1);
    localparam logic [REG_IDX_W-1:0] REG_CODE_TWO     = REG_IDX_W'(2);
    localparam logic [REG_IDX_W-1:0] REG_CODE_THREE   = REG_IDX_W'(3);
    localparam logic [REG_IDX_W-1:0] REG_DEFAULT_CODE = REG_IDX_W'(4);

    localparam logic [15:0] CODE_RESET [NUM_REGS] =
        '{16'd25966, 16'd25701, 16'd26226, 16'd30059, 16'd25966};

    localparam logic [15:0] QUALITY_ONE = 16'd1000;
    localparam logic [15:0] QUALITY_MAX = 16'hFFFF;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CH_Q     = 8'h71;
    localparam logic [7:0] CASE_OFS = 8'h20;

    typedef enum logic [1:0] {
        MK_NONE = 2'd0,
        MK_SEMI = 2'd1,
        MK_Q    = 2'd2
    } marker_t;

    typedef enum logic [2:0] {
        NP_SEARCH = 3'd0,
        NP_BLANK  = 3'd1,
        NP_INT    = 3'd2,
        NP_FRAC   = 3'd3,
        NP_DONE   = 3'd4
    } num_phase_t;

    typedef struct packed {
        logic        started;
        logic [15:0] tag_chars;
        logic [1:0]  tag_len;
        logic        tag_closed;
        marker_t     marker;
        num_phase_t  num_phase;
        logic [15:0] quality;
        logic [1:0]  frac_digits;
    } entry_t;

    localparam entry_t ENTRY_CLEAR = '{
        started:     1'b0,
        tag_chars:   16'd0,
        tag_len:     2'd0,
        tag_closed:  1'b0,
        marker:      MK_NONE,
        num_phase:   NP_SEARCH,
        quality:     16'd0,
        frac_digits: 2'd0
    };

endpackage

// ===== rtl/accept_language_select_top.sv =====
// accept-language selector: byte parser, code match and result register
//
//  channel  | handshake            | word
//  ---------+----------------------+---------------------------------------------
//  input    | in_valid / in_stall  | header_byte, last_byte
//  output   | out_valid / out_stall| chosen_code, matched, chosen_quality,
//           |                      | chosen_slot
//  config   | apb write/read       | code_zero..code_three, default_code
//
// one byte per cycle while in_stall is low; each byte updates the entry state in a single pass
// a result lands in the output register in the cycle after its last byte is accepted
// in_stall is high only while a result sits in the output register unclaimed
// rst_n (async, active low) clears parser state and restores the codes

module accept_language_select_top
    import als_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  header_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] chosen_code,
    output logic        matched,
    output logic [15:0] chosen_quality,
    output logic [1:0]  chosen_slot,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [15:0]      code_reg [NUM_REGS];
    logic [CNT_W-1:0] count_reg, count_next;
    logic             ended_reg, ended_next;
    entry_t           entry_reg, entry_next;
    logic             best_valid_reg, best_valid_next;
    logic [15:0]      best_q_reg, best_q_next;
    logic [1:0]       best_slot_reg, best_slot_next;
    logic             out_valid_reg;
    logic [15:0]      out_code_reg, out_code_next;
    logic             out_matched_reg;
    logic [15:0]      out_q_reg, out_q_next;
    logic [1:0]       out_slot_reg, out_slot_next;

    logic             accept;
    logic             active;
    logic             sep;
    entry_t           ent_after;
    entry_t           fin_src;
    logic             fin_en;
    logic [15:0]      fin_q;
    logic             hit;
    logic [1:0]       hit_slot;
    logic             update;
    logic [REG_IDX_W-1:0] reg_idx;

    function automatic logic [15:0] sat16(input logic [19:0] s);
        return (s > 20'(QUALITY_MAX)) ? QUALITY_MAX : s[15:0];
    endfunction

    function automatic entry_t take_char(input entry_t e, input logic [7:0] c);
        entry_t     r;
        logic       digit;
        logic       blank;
        logic [3:0] d;
        logic [7:0] lc;
        logic [6:0] w;
        r     = e;
        digit = (c >= CH_ZERO) && (c <= CH_NINE);
        blank = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
        d     = c[3:0];
        lc    = ((c >= CH_UP_A) && (c <= CH_UP_Z)) ? c + CASE_OFS : c;
        w     = (e.frac_digits == 2'd0) ? 7'd100 : ((e.frac_digits == 2'd1) ? 7'd10 : 7'd1);
        // leading spaces of an entry are dropped entirely
        if (e.started || (c != CH_SPACE))
        begin
            r.started = 1'b1;
            if (!e.tag_closed)
            begin
                if ((c == CH_DASH) || (c == CH_SEMI))
                begin
                    r.tag_closed = 1'b1;
                end
                else
                begin
                    r.tag_chars = {e.tag_chars[7:0], lc};
                    r.tag_len   = e.tag_len + 2'd1;
                    if (e.tag_len != 2'd0)
                    begin
                        r.tag_closed = 1'b1;
                    end
                end
            end
            unique case (e.num_phase)
                NP_SEARCH:
                begin
                    if ((e.marker == MK_SEMI) && (c == CH_Q))
                    begin
                        r.marker = MK_Q;
                    end
                    else if ((e.marker == MK_Q) && (c == CH_EQ))
                    begin
                        r.marker    = MK_NONE;
                        r.num_phase = NP_BLANK;
                    end
                    else
                    begin
                        r.marker = (c == CH_SEMI) ? MK_SEMI : MK_NONE;
                    end
                end
                NP_BLANK:
                begin
                    if (!blank)
                    begin
                        if (digit)
                        begin
                            r.quality   = sat16(20'(d) * 20'd1000);
                            r.num_phase = NP_INT;
                        end
                        else if (c == CH_DOT)
                        begin
                            r.num_phase = NP_FRAC;
                        end
                        else
                        begin
                            r.num_phase = NP_DONE;
                        end
                    end
                end
                NP_INT:
                begin
                    if (digit)
                    begin
                        r.quality = sat16(20'(e.quality) * 20'd10 + 20'(d) * 20'd1000);
                    end
                    else if (c == CH_DOT)
                    begin
                        r.num_phase = NP_FRAC;
                    end
                    else
                    begin
                        r.num_phase = NP_DONE;
                    end
                end
                NP_FRAC:
                begin
                    if (digit)
                    begin
                        // digits past the third are truncated
                        if (e.frac_digits != 2'd3)
                        begin
                            r.quality     = sat16(20'(e.quality) + 20'(d) * 20'(w));
                            r.frac_digits = e.frac_digits + 2'd1;
                        end
                    end
                    else
                    begin
                        r.num_phase = NP_DONE;
                    end
                end
                NP_DONE:
                begin
                    r.num_phase = NP_DONE;
                end
                default:
                begin
                    r.num_phase = NP_DONE;
                end
            endcase
        end
        return r;
    endfunction

    assign accept   = in_valid && !in_stall;
    assign in_stall = out_valid_reg && out_stall;
    assign pready   = 1'b1;
    assign reg_idx  = paddr[4:2];

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                code_reg[i] <= CODE_RESET[i];
            end
        end
        else if (psel && penable && pwrite && (32'(reg_idx) < 32'(NUM_REGS)))
        begin
            code_reg[reg_idx] <= pwdata[15:0];
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_CODE_ZERO:    prdata = {16'd0, code_reg[REG_CODE_ZERO]};
            REG_CODE_ONE:     prdata = {16'd0, code_reg[REG_CODE_ONE]};
            REG_CODE_TWO:     prdata = {16'd0, code_reg[REG_CODE_TWO]};
            REG_CODE_THREE:   prdata = {16'd0, code_reg[REG_CODE_THREE]};
            REG_DEFAULT_CODE: prdata = {16'd0, code_reg[REG_DEFAULT_CODE]};
            default:          prdata = 32'd0;
        endcase
    end

    // byte parse
    always_comb
    begin
        active = !ended_reg && (count_reg < CNT_W'(MAX_HEADER_BYTES));
        sep    = (header_byte == CH_NUL) || (header_byte == CH_COMMA);
        if (!active)
        begin
            ent_after = entry_reg;
        end
        else if (sep)
        begin
            ent_after = ENTRY_CLEAR;
        end
        else
        begin
            ent_after = take_char(entry_reg, header_byte);
        end
        // a separator closes the old entry; otherwise the last byte closes the new one
        fin_src = (active && sep) ? entry_reg : ent_after;
        fin_en  = (active && sep) || (last_byte && !ended_reg);
        fin_q   = (fin_src.num_phase == NP_SEARCH) ? QUALITY_ONE : fin_src.quality;
    end

    // lowest matching slot wins
    always_comb
    begin
        hit      = 1'b0;
        hit_slot = 2'd0;
        for (int i = NUM_CODES - 1; i >= 0; i--)
        begin
            if (fin_src.tag_chars == code_reg[i])
            begin
                hit      = 1'b1;
                hit_slot = 2'(i);
            end
        end
        hit = hit && (fin_src.tag_len == 2'd2);
    end

    always_comb
    begin
        update          = fin_en && hit && (!best_valid_reg || (fin_q > best_q_reg));
        best_valid_next = best_valid_reg || update;
        best_q_next     = update ? fin_q : best_q_reg;
        best_slot_next  = update ? hit_slot : best_slot_reg;
        ended_next      = ended_reg || (active && (header_byte == CH_NUL));
        count_next      = active ? count_reg + CNT_W'(1) : count_reg;
        entry_next      = ent_after;
        out_code_next   = best_valid_next ? code_reg[REG_IDX_W'(best_slot_next)]
                                          : code_reg[REG_DEFAULT_CODE];
        out_q_next      = best_valid_next ? best_q_next : 16'd0;
        out_slot_next   = best_valid_next ? best_slot_next : 2'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            ended_reg      <= 1'b0;
            entry_reg      <= ENTRY_CLEAR;
            best_valid_reg <= 1'b0;
            best_q_reg     <= 16'd0;
            best_slot_reg  <= 2'd0;
        end
        else if (accept)
        begin
            if (last_byte)
            begin
                count_reg      <= '0;
                ended_reg      <= 1'b0;
                entry_reg      <= ENTRY_CLEAR;
                best_valid_reg <= 1'b0;
                best_q_reg     <= 16'd0;
                best_slot_reg  <= 2'd0;
            end
            else
            begin
                count_reg      <= count_next;
                ended_reg      <= ended_next;
                entry_reg      <= entry_next;
                best_valid_reg <= best_valid_next;
                best_q_reg     <= best_q_next;
                best_slot_reg  <= best_slot_next;
            end
        end
    end

    // output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept && last_byte)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && last_byte)
        begin
            out_code_reg    <= out_code_next;
            out_matched_reg <= best_valid_next;
            out_q_reg       <= out_q_next;
            out_slot_reg    <= out_slot_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign chosen_code    = out_code_reg;
    assign matched        = out_matched_reg;
    assign chosen_quality = out_q_reg;
    assign chosen_slot    = out_slot_reg;

endmodule

// ===== rtl/als_checker.sv =====
// port-level checks for the accept-language selector, bound to the top level
`include "assert_macros.svh"

module als_checker
    import als_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        last_byte,
    input logic        out_valid,
    input logic        out_stall,
    input logic [15:0] chosen_code,
    input logic        matched,
    input logic [15:0] chosen_quality,
    input logic [1:0]  chosen_slot,
    input logic        pready
);

    // a held word keeps its value
    `ALS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(chosen_code) && $stable(chosen_quality) && $stable(matched))

    // an unmatched word carries no quality and no slot
    `ALS_ASSERT_IMPL(a_unmatched_zero, out_valid && !matched, chosen_quality == 16'd0 && chosen_slot == 2'd0)

    // a new word only follows an accepted last byte
    `ALS_ASSERT_IMPL(a_word_after_last, $rose(out_valid), $past(in_valid && !in_stall && last_byte))

    // input is held back only by an unclaimed word
    `ALS_ASSERT_IMPL(a_stall_cause, in_stall, out_valid && out_stall)

    `ALS_ASSERT(a_pready_high, pready)

endmodule

bind accept_language_select_top als_checker u_als_checker (.*);
